[rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ERHM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ERHM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define ERHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ERHM_ASSERT(lbl, clk, rstn, prop, msg)
`define ERHM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ERHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/erhm_pkg.sv]
package erhm_pkg;

    localparam int FREQ_W  = 16;
    localparam int HOURS_W = 16;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam logic [FREQ_W-1:0]  FREQ_MAX      = 16'hFFFF;
    localparam logic [HOURS_W-1:0] HOURS_MAX     = 16'hFFFF;
    localparam logic [FREQ_W-1:0]  THRESH_RESET  = 16'd80;
    localparam logic [SEC_W-1:0]   SEC_PER_MIN   = 6'd60;
    localparam logic [MIN_W-1:0]   MIN_PER_HOUR  = 6'd60;

    typedef enum logic [1:0] {
        MODE_WAIT     = 2'd0,
        MODE_STARTING = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_STOPPING = 2'd3
    } mode_t;

    // Gate timing events for the tick being processed.
    typedef struct packed {
        logic check;     // half-gate or full-gate tick: evaluate mode
        logic gate_end;  // full-gate tick: latch frequency, advance time
    } gate_evt_t;

endpackage

[rtl/erhm_gate.sv]
module erhm_gate
    import erhm_pkg::*;
#(
    parameter int TICKS_PER_GATE = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              proc,
    input  logic              func,
    output gate_evt_t         evt,
    output logic [FREQ_W-1:0] freq_reg_o,
    output logic [FREQ_W-1:0] freq_next_o
);

    localparam int PHASE_W = $clog2(TICKS_PER_GATE + 1);
    localparam logic [PHASE_W-1:0] HALF_TICK = PHASE_W'(TICKS_PER_GATE / 2);
    localparam logic [PHASE_W-1:0] FULL_TICK = PHASE_W'(TICKS_PER_GATE);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_inc;
    logic [FREQ_W-1:0]  pulse_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic               is_half;
    logic               is_end;

    assign phase_inc = phase_reg + PHASE_W'(1);
    assign is_half   = (phase_inc == HALF_TICK);
    assign is_end    = (phase_inc >= FULL_TICK);

    assign evt.check    = func & (is_half | is_end);
    assign evt.gate_end = func & is_end;

    assign freq_reg_o  = freq_reg;
    assign freq_next_o = (proc && evt.gate_end) ? pulse_reg : freq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            pulse_reg <= '0;
            freq_reg  <= '0;
        end else if (proc) begin
            if (!func) begin
                if (pulse_reg != FREQ_MAX) begin
                    pulse_reg <= pulse_reg + FREQ_W'(1);
                end
            end else if (is_end) begin
                phase_reg <= '0;
                freq_reg  <= pulse_reg;
                pulse_reg <= '0;
            end else begin
                phase_reg <= phase_inc;
            end
        end
    end

endmodule

[rtl/erhm_runtime.sv]
module erhm_runtime
    import erhm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               proc,
    input  logic               start_level,
    input  gate_evt_t          evt,
    input  logic [FREQ_W-1:0]  freq,
    input  logic [FREQ_W-1:0]  threshold,
    output mode_t              mode_next_o,
    output logic [HOURS_W-1:0] hours_next_o,
    output logic [MIN_W-1:0]   minutes_next_o,
    output logic [SEC_W-1:0]   seconds_next_o
);

    mode_t               mode_reg;
    mode_t               mode_chk;
    logic [HOURS_W-1:0]  hours_reg;
    logic [MIN_W-1:0]    minutes_reg;
    logic [SEC_W-1:0]    seconds_reg;
    logic [SEC_W-1:0]    sec_inc;
    logic [MIN_W-1:0]    min_tmp;

    // Mode check uses the frequency latched at the previous gate end.
    always_comb begin
        mode_chk = mode_reg;
        unique case (mode_reg)
            MODE_WAIT: begin
                if (start_level) mode_chk = MODE_STARTING;
            end
            MODE_STARTING: begin
                if (freq > threshold) mode_chk = MODE_RUNNING;
            end
            MODE_RUNNING: begin
                if (freq < threshold) mode_chk = MODE_STOPPING;
            end
            MODE_STOPPING: begin
                mode_chk = MODE_STOPPING;
            end
            default: begin
                mode_chk = mode_reg;
            end
        endcase
    end

    always_comb begin
        mode_next_o    = (proc && evt.check) ? mode_chk : mode_reg;
        hours_next_o   = hours_reg;
        minutes_next_o = minutes_reg;
        seconds_next_o = seconds_reg;
        sec_inc        = seconds_reg + SEC_W'(1);
        min_tmp        = minutes_reg;
        if (proc && evt.gate_end && (mode_next_o == MODE_RUNNING)) begin
            if (sec_inc >= SEC_PER_MIN) begin
                seconds_next_o = '0;
                min_tmp        = minutes_reg + MIN_W'(1);
            end else begin
                seconds_next_o = sec_inc;
            end
            if (min_tmp >= MIN_PER_HOUR) begin
                minutes_next_o = '0;
                if (hours_reg != HOURS_MAX) begin
                    hours_next_o = hours_reg + HOURS_W'(1);
                end
            end else begin
                minutes_next_o = min_tmp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_WAIT;
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
        end else begin
            mode_reg    <= mode_next_o;
            hours_reg   <= hours_next_o;
            minutes_reg <= minutes_next_o;
            seconds_reg <= seconds_next_o;
        end
    end

endmodule

[rtl/engine_run_hour_meter_core.sv]
// Engine run-hour meter core.
// The s_ channel carries events: s_func = 0 is a pulse edge from the speed
// sensor, s_func = 1 is a timer tick (TICKS_PER_GATE ticks per one-second gate)
// that also carries the start input level on s_start_level.
// Every accepted transaction produces exactly one result transaction on the
// m_ channel: the current mode, the frequency latched at the last gate end,
// the accumulated run time, and m_gate_done when that tick closed a gate.
// The cfg channel writes the run threshold; it is always ready and should be
// used only while the core is idle.
// A transaction accepted on s_ is captured in the input register, processed,
// and offered on m_ from the output register. Throughput is one transaction per
// cycle while the receiver does not stall, set by the single processing stage
// between the input register and the output register.
// When the receiver stalls, the result stays in the output register and one
// more transaction is held in the input register; s_ready then drops.
// Reset (synchronous, active low) clears all counters, sets mode to wait, sets
// the threshold to 80 and empties both registers.
`include "assert_macros.svh"

module engine_run_hour_meter_core
    import erhm_pkg::*;
#(
    parameter int TICKS_PER_GATE = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FREQ_W-1:0]  cfg_data,
    // Event input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic               s_start_level,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_mode,
    output logic [FREQ_W-1:0]  m_frequency,
    output logic [HOURS_W-1:0] m_hours,
    output logic [MIN_W-1:0]   m_minutes,
    output logic [SEC_W-1:0]   m_seconds,
    output logic               m_gate_done
);

    // Threshold register; writes are always accepted.
    logic [FREQ_W-1:0] thresh_reg;

    // Input register.
    logic in_valid_reg;
    logic in_func_reg;
    logic in_start_reg;

    // Output register.
    logic               m_valid_reg;
    mode_t              m_mode_reg;
    logic [FREQ_W-1:0]  m_freq_reg;
    logic [HOURS_W-1:0] m_hours_reg;
    logic [MIN_W-1:0]   m_minutes_reg;
    logic [SEC_W-1:0]   m_seconds_reg;
    logic               m_gate_done_reg;

    // Processing control: the held event is processed when the output
    // register is empty or being drained this cycle.
    logic advance;
    logic proc;

    gate_evt_t          evt;
    logic [FREQ_W-1:0]  freq_cur;
    logic [FREQ_W-1:0]  freq_next;
    mode_t              mode_next;
    logic [HOURS_W-1:0] hours_next;
    logic [MIN_W-1:0]   minutes_next;
    logic [SEC_W-1:0]   seconds_next;

    // Terms used by the checks at the end of the module.
    logic pulse_proc;
    logic time_ok;
    logic mode_stop;
    logic out_stopping;
    logic in_stalled;

    assign advance   = !m_valid_reg || m_ready;
    assign proc      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    erhm_gate #(
        .TICKS_PER_GATE(TICKS_PER_GATE)
    ) u_gate (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .proc        (proc),
        .func        (in_func_reg),
        .evt         (evt),
        .freq_reg_o  (freq_cur),
        .freq_next_o (freq_next)
    );

    erhm_runtime u_runtime (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .proc           (proc),
        .start_level    (in_start_reg),
        .evt            (evt),
        .freq           (freq_cur),
        .threshold      (thresh_reg),
        .mode_next_o    (mode_next),
        .hours_next_o   (hours_next),
        .minutes_next_o (minutes_next),
        .seconds_next_o (seconds_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thresh_reg <= cfg_data;
        end
    end

    // Input register: loads a new transaction whenever it has room.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_func_reg  <= s_func;
            in_start_reg <= s_start_level;
        end
    end

    // Output register: captures the state after the processed event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
        if (proc) begin
            m_mode_reg      <= mode_next;
            m_freq_reg      <= freq_next;
            m_hours_reg     <= hours_next;
            m_minutes_reg   <= minutes_next;
            m_seconds_reg   <= seconds_next;
            m_gate_done_reg <= evt.gate_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_mode      = m_mode_reg;
    assign m_frequency = m_freq_reg;
    assign m_hours     = m_hours_reg;
    assign m_minutes   = m_minutes_reg;
    assign m_seconds   = m_seconds_reg;
    assign m_gate_done = m_gate_done_reg;

    assign pulse_proc   = proc && !in_func_reg;
    assign time_ok      = (m_minutes_reg < MIN_PER_HOUR) && (m_seconds_reg < SEC_PER_MIN);
    assign mode_stop    = (m_mode_reg == MODE_STOPPING);
    assign out_stopping = m_valid_reg && mode_stop;
    assign in_stalled   = in_valid_reg && !advance;

    // A pulse event can never close a gate.
    `ERHM_ASSERT_IMPL(a_pulse_no_gate, aclk, aresetn, pulse_proc, !evt.gate_end, "pulse ended a gate")

    // The run-time counter fields stay in range.
    `ERHM_ASSERT_IMPL(a_time_range, aclk, aresetn, m_valid_reg, time_ok, "run time out of range")

    // Stopping is sticky in the delivered results.
    `ERHM_ASSERT_NEXT(a_stop_sticky, aclk, aresetn, out_stopping, mode_stop, "left stopping")

    // An empty output register never blocks the input.
    `ERHM_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready, "blocked when empty")

    // A held event is kept until it is processed.
    `ERHM_ASSERT_NEXT(a_hold_input, aclk, aresetn, in_stalled, in_valid_reg, "held event dropped")

endmodule
